@@ rtl/core/tsp_pkg.sv @@
// Package: shared types, constants and codes for the trapezoid step profile block.
package tsp_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int TIME_BITS    = 32;
  localparam int FRAC_W       = 16;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_ABS  = 2'd1,
    ACT_REL  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_MUL_D,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] target_pos;
    logic [31:0] move_time_us;
    logic [15:0] acc_fraction;
    logic [15:0] dec_fraction;
    logic [31:0] elapsed_us;
  } in_beat_t;

  typedef struct packed {
    logic        step_pulse;
    logic        dir_level;
    logic [15:0] position;
    logic [15:0] steps_taken;
    logic        move_finished;
    logic        move_rejected;
  } out_beat_t;

endpackage

@@ rtl/core/tsp_if.sv @@
// Interfaces: valid/ready channels for input, result and configuration beats.
interface tsp_in_if;
  import tsp_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tsp_out_if;
  import tsp_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tsp_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/tsp_mul.sv @@
// Shared multiplier: 64x64 product built from one 32x32 partial product per cycle.
module tsp_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);
  import tsp_pkg::*;

  logic [63:0]  a_r, b_r;
  logic [1:0]   idx_r;
  logic         busy_r;
  logic [127:0] acc_r;
  logic [63:0]  pp_r;
  logic [1:0]   pidx_r;
  logic         pv_r, plast_r;
  logic         done_r;
  logic [31:0]  opa, opb;

  // pick the halves for this partial product
  always_comb begin
    opa = idx_r[0] ? a_r[63:32] : a_r[31:0];
    opb = idx_r[1] ? b_r[63:32] : b_r[31:0];
  end

  // sequence partial products, then accumulate each one in the cycle after it is formed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pv_r    <= 1'b0;
      plast_r <= 1'b0;
      done_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      done_r <= pv_r && plast_r;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        idx_r  <= '0;
        busy_r <= 1'b1;
        acc_r  <= '0;
        pv_r   <= 1'b0;
      end else begin
        pv_r    <= busy_r;
        plast_r <= busy_r && (idx_r == 2'd3);
        if (busy_r) begin
          pp_r   <= opa * opb;
          pidx_r <= idx_r;
          idx_r  <= idx_r + 2'd1;
          if (idx_r == 2'd3) busy_r <= 1'b0;
        end
        if (pv_r) begin
          acc_r <= acc_r + ({64'd0, pp_r} << (7'd32 * ({5'd0, pidx_r[0]} + {5'd0, pidx_r[1]})));
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

@@ rtl/core/trapezoid_step_profile.sv @@
// Trapezoid step profile: one item in, one status beat out, sequenced over a shared multiplier.
// Each 64x64 product runs on the shared 32x32 unit in steps: start, four partials, sum, hand-off.
// A tick in the accelerate or decelerate phase uses four products, a cruise tick or a move to a
// new position uses two, and any other item uses none.
// Not ready from the input beat until the result beat leaves: no new item is taken before then.
// Synchronous active-low reset: position 0, direction up, no move pending, reverse_dir 0.
module trapezoid_step_profile #(
  parameter int POS_BITS = tsp_pkg::POS_BITS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  tsp_in_if.sink  in_ch,
  tsp_out_if.source out_ch,
  tsp_cfg_if.sink cfg_ch
);
  import tsp_pkg::*;

  state_t state_r, state_nxt;
  logic   rev_r;
  logic [POS_BITS-1:0] pos_r, need_r, issued_r;
  logic   up_r;
  logic [33:0] w_r;
  logic [31:0] ta_r, td_r, cr_r;
  in_beat_t it_r;
  logic [127:0] lhs_r, p1_r;
  logic         out_v_r;
  out_beat_t    out_r;
  logic         rej_r, pulse_hold_r, mul_busy_r;

  logic         mstart, mdone;
  logic [63:0]  ma, mb;
  logic [127:0] mp;

  tsp_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
                 .done(mdone), .prod(mp));

  // tick phase decode
  logic [31:0] t, u, v, d;
  logic [POS_BITS:0] k;
  logic [POS_BITS-1:0] rem;
  logic ph_acc, ph_cru, ph_after, pend;
  always_comb begin
    t        = it_r.elapsed_us;
    u        = t - ta_r;
    v        = u - cr_r;
    d        = td_r - v;
    k        = {1'b0, issued_r} + (POS_BITS+1)'(1);
    rem      = need_r - issued_r - POS_BITS'(1);
    ph_acc   = t <= ta_r;
    ph_cru   = !ph_acc && (u < cr_r);
    ph_after = !ph_acc && !ph_cru && (v >= td_r);
    pend     = issued_r < need_r;
  end

  // move decode
  logic [POS_BITS-1:0] tval, tgt, delta;
  always_comb begin
    tval  = POS_BITS'($signed(it_r.target_pos));
    tgt   = (it_r.action == ACT_ABS) ? tval : pos_r + tval;
    delta = tgt - pos_r;
  end

  wire is_tick  = (it_r.action == ACT_TICK);
  wire is_move  = (it_r.action == ACT_ABS) || (it_r.action == ACT_REL);
  wire run_move = is_move && (tgt != pos_r);
  wire need_mul = is_tick && pend && !ph_after;
  wire mul_fin  = mul_busy_r && mdone;

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      ST_MUL_A: begin
        if (is_move) begin
          ma = {32'd0, it_r.move_time_us};
          mb = {48'd0, it_r.acc_fraction};
        end else if (ph_acc) begin
          ma = {32'd0, t};
          mb = {32'd0, t};
        end else if (ph_cru) begin
          ma = 64'(need_r);
          mb = {32'd0, ta_r} + {31'd0, u, 1'b0};
        end else begin
          ma = 64'(rem);
          mb = {32'd0, td_r};
        end
      end
      ST_MUL_B: begin
        if (is_move) begin
          ma = {32'd0, it_r.move_time_us};
          mb = {48'd0, it_r.dec_fraction};
        end else if (ph_acc) begin
          ma = 64'(need_r);
          mb = lhs_r[63:0];
        end else if (ph_cru) begin
          ma = 64'(k);
          mb = {30'd0, w_r};
        end else begin
          ma = lhs_r[63:0];
          mb = {30'd0, w_r};
        end
      end
      ST_MUL_C: begin
        if (ph_acc) begin
          ma = 64'(k);
          mb = {32'd0, ta_r};
        end else begin
          ma = {32'd0, d};
          mb = {32'd0, d};
        end
      end
      ST_MUL_D: begin
        if (ph_acc) begin
          ma = p1_r[63:0];
          mb = {30'd0, w_r};
        end else begin
          ma = 64'(need_r);
          mb = p1_r[63:0];
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid && in_ch.ready) state_nxt = ST_MUL_A;
      ST_MUL_A: begin
        if (!(need_mul || run_move)) state_nxt = ST_DONE;
        else if (mul_fin) state_nxt = ST_MUL_B;
      end
      ST_MUL_B: if (mul_fin) state_nxt = (is_move || ph_cru) ? ST_DONE : ST_MUL_C;
      ST_MUL_C: if (mul_fin) state_nxt = ST_MUL_D;
      ST_MUL_D: if (mul_fin) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // start a product on entry to each multiply state
  always_comb begin
    mstart = 1'b0;
    unique case (state_r)
      ST_MUL_A: mstart = (need_mul || run_move) && !mul_busy_r;
      ST_MUL_B, ST_MUL_C, ST_MUL_D: mstart = !mul_busy_r;
      default: mstart = 1'b0;
    endcase
  end

  assign in_ch.ready  = (state_r == ST_IDLE) && !out_v_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // hold the busy flag from product start to done
  always_ff @(posedge clk) begin
    if (!rst_n) mul_busy_r <= 1'b0;
    else if (mstart) mul_busy_r <= 1'b1;
    else if (mdone) mul_busy_r <= 1'b0;
  end

  // advance the sequencer, take configuration, hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rev_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) rev_r <= cfg_ch.data;
      if (state_r == ST_DONE) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  // latch the input beat
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) it_r <= in_ch.data;
  end

  // keep products for the two-sided compares
  always_ff @(posedge clk) begin
    if (mul_fin) begin
      unique case (state_r)
        ST_MUL_A: lhs_r <= mp;
        ST_MUL_B: if (!is_move) lhs_r <= mp;
        ST_MUL_C: p1_r <= mp;
        default: ;
      endcase
    end
  end

  // decide the step and the reject flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_hold_r <= 1'b0;
      rej_r        <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      pulse_hold_r <= 1'b0;
      rej_r        <= 1'b0;
    end else begin
      unique case (state_r)
        ST_MUL_A: if (is_tick && pend && ph_after) pulse_hold_r <= 1'b1;
        ST_MUL_B: begin
          if (mul_fin && is_move && lhs_r[47:16] == 32'd0) rej_r <= 1'b1;
          else if (mul_fin && is_tick && ph_cru) pulse_hold_r <= lhs_r >= mp;
        end
        ST_MUL_D: if (mul_fin) pulse_hold_r <= lhs_r >= mp;
        default: ;
      endcase
    end
  end

  logic [POS_BITS-1:0] pos_n, iss_n;
  always_comb begin
    pos_n = pulse_hold_r ? (up_r ? pos_r + POS_BITS'(1) : pos_r - POS_BITS'(1)) : pos_r;
    iss_n = pulse_hold_r ? issued_r + POS_BITS'(1) : issued_r;
  end

  // load a new move, advance position on a step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      up_r     <= 1'b1;
      need_r   <= '0;
      issued_r <= '0;
      ta_r     <= '0;
      td_r     <= '0;
      cr_r     <= '0;
      w_r      <= '0;
    end else if (state_r == ST_MUL_B && mul_fin && is_move && lhs_r[47:16] != 32'd0) begin
      up_r     <= !delta[POS_BITS-1];
      need_r   <= delta[POS_BITS-1] ? -delta : delta;
      issued_r <= '0;
      ta_r     <= lhs_r[47:16];
      td_r     <= mp[47:16];
      w_r      <= {1'b0, it_r.move_time_us, 1'b0} - {2'd0, lhs_r[47:16]}
                  - {2'd0, mp[47:16]};
      cr_r     <= ({1'b0, lhs_r[47:16]} + {1'b0, mp[47:16]} <
                   {1'b0, it_r.move_time_us}) ?
                  it_r.move_time_us - lhs_r[47:16] - mp[47:16] : 32'd0;
    end else if (state_r == ST_DONE && pulse_hold_r) begin
      pos_r    <= pos_n;
      issued_r <= iss_n;
    end
  end

  // build the status beat
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) begin
      out_r.step_pulse    <= pulse_hold_r;
      out_r.dir_level     <= up_r ^ rev_r;
      out_r.position      <= 16'(pos_n);
      out_r.steps_taken   <= 16'(iss_n);
      out_r.move_finished <= iss_n == need_r;
      out_r.move_rejected <= rej_r;
    end
  end
endmodule

@@ rtl/core/tsp_checker.sv @@
// Checker: port-level properties of the trapezoid step profile block, bound to the top level.
module tsp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_pulse,
  input logic out_rej
);
  a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("beat dropped");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("taken while result waits");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_pulse && out_rej)) else $error("pulse on rejected move");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready while busy");
endmodule

bind trapezoid_step_profile tsp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_pulse(out_ch.data.step_pulse), .out_rej(out_ch.data.move_rejected));
